// ----- rtl/core/tft_pkg.sv -----
package tft_pkg;

  // Table geometry
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned TIME_W = 16;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_BITS  = CMD_W + KEY_W + 2 * TIME_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = 2;
  localparam int unsigned OUT_W    = 8;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

endpackage

// ----- rtl/core/timed_flag_table_core.sv -----
// Flow: a command beat is taken in ST_IDLE, ST_SCAN visits every entry, ST_APPLY acts on
//   the chosen entry and registers the result, and ST_OUT holds it until m_axis_tready_i.
// Throughput: one entry is visited per cycle by a single key compare / 16-bit subtract unit,
//   and the input is not ready until the result is taken: one command at a time.
// Reset: rst_ni (asynchronous, active low) clears every valid bit and the sequencer at once;
//   no clearing pass is needed and the block is ready in the first cycle after reset.
module timed_flag_table_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Command beat
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // tdata: command[1:0], flag_id[17:2], duration[33:18], elapsed[49:34], zero pad
  input  logic [tft_pkg::IN_W-1:0] s_axis_tdata_i,
  // Result beat
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // tdata: present[0], add_dropped[1], zero pad
  output logic [tft_pkg::OUT_W-1:0] m_axis_tdata_o
);

  localparam int unsigned IW = tft_pkg::IDX_W;
  localparam int unsigned KW = tft_pkg::KEY_W;
  localparam int unsigned TW = tft_pkg::TIME_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(tft_pkg::ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_OUT
  } state_e;

  // Entry storage
  logic [tft_pkg::ENTRIES-1:0] valid_q;
  logic [KW-1:0] key_mem [tft_pkg::ENTRIES];
  logic [TW-1:0] dur_mem [tft_pkg::ENTRIES];
  logic [TW-1:0] rem_mem [tft_pkg::ENTRIES];

  // Sequencer state
  state_e          state_q;
  tft_pkg::cmd_e   cmd_q;
  logic [KW-1:0]   key_q;
  logic [TW-1:0]   dur_q;
  logic [TW-1:0]   el_q;
  logic [IW-1:0]   idx_q;
  logic            hit_q;
  logic [IW-1:0]   hit_idx_q;
  logic            free_q;
  logic [IW-1:0]   free_idx_q;
  logic [tft_pkg::OUT_W-1:0] out_q;

  // Shared entry read port, data registered from the address so that it lines up with rd_idx_q
  logic [IW-1:0] rd_idx_d;
  logic [IW-1:0] rd_idx_q;
  logic [KW-1:0] rd_key_q;
  logic [TW-1:0] rd_dur_q;
  logic [TW-1:0] rd_rem_q;
  logic          rd_valid;

  // Shared compare / subtract unit
  logic          key_eq;
  logic [TW:0]   diff;
  logic          expire;

  // Write controls
  logic          we_set_valid;
  logic          we_clr_valid;
  logic          we_key;
  logic          we_dur;
  logic          we_rem;
  logic [IW-1:0] wr_idx;
  logic [TW-1:0] wr_rem;
  logic          present;
  logic          dropped;

  // Pick the entry to read next: the next scan slot, or the entry the command acts on
  always_comb begin
    rd_idx_d = rd_idx_q;
    case (state_q)
      ST_IDLE: begin
        rd_idx_d = '0;
      end
      ST_SCAN: begin
        if (idx_q != LAST_IDX) begin
          rd_idx_d = idx_q + 1'b1;
        end else if (hit_q) begin
          rd_idx_d = hit_idx_q;
        end else if (key_eq || !free_q) begin
          rd_idx_d = idx_q;
        end else begin
          rd_idx_d = free_idx_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_valid = valid_q[rd_idx_q];

  assign key_eq = rd_valid && (rd_key_q == key_q);
  assign diff   = {1'b0, rd_rem_q} - {1'b0, el_q};
  assign expire = diff[TW] || (diff[TW-1:0] == '0);

  // Decide the write for this cycle
  always_comb begin
    we_set_valid = 1'b0;
    we_clr_valid = 1'b0;
    we_key       = 1'b0;
    we_dur       = 1'b0;
    we_rem       = 1'b0;
    wr_idx       = rd_idx_q;
    wr_rem       = dur_q;
    present      = 1'b0;
    dropped      = 1'b0;
    case (state_q)
      ST_SCAN: begin
        // age one timed, running entry
        if (cmd_q == tft_pkg::CMD_TICK && rd_valid && rd_dur_q != '0 && rd_rem_q != '0) begin
          if (expire) begin
            we_clr_valid = 1'b1;
          end else begin
            we_rem = 1'b1;
            wr_rem = diff[TW-1:0];
          end
        end
      end
      ST_APPLY: begin
        case (cmd_q)
          tft_pkg::CMD_ADD: begin
            if (hit_q) begin
              we_dur = 1'b1;
              we_rem = 1'b1;
            end else if (free_q) begin
              we_set_valid = 1'b1;
              we_key       = 1'b1;
              we_dur       = 1'b1;
              we_rem       = 1'b1;
            end else begin
              dropped = 1'b1;
            end
          end
          tft_pkg::CMD_REMOVE: begin
            if (hit_q) begin
              if (rd_dur_q != '0) begin
                we_rem = 1'b1;
                wr_rem = rd_dur_q;
              end else begin
                we_clr_valid = 1'b1;
              end
            end
          end
          tft_pkg::CMD_QUERY: begin
            present = hit_q && (rd_rem_q != '0 || rd_dur_q == '0);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Entry payload writes and registered read
  always_ff @(posedge clk_i) begin
    if (we_key) begin
      key_mem[wr_idx] <= key_q;
    end
    if (we_dur) begin
      dur_mem[wr_idx] <= dur_q;
    end
    if (we_rem) begin
      rem_mem[wr_idx] <= wr_rem;
    end
    rd_key_q <= key_mem[rd_idx_d];
    rd_dur_q <= dur_mem[rd_idx_d];
    rd_rem_q <= rem_mem[rd_idx_d];
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_set_valid) begin
      valid_q[wr_idx] <= 1'b1;
    end else if (we_clr_valid) begin
      valid_q[wr_idx] <= 1'b0;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmd_q      <= tft_pkg::CMD_ADD;
      key_q      <= '0;
      dur_q      <= '0;
      el_q       <= '0;
      idx_q      <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      out_q      <= '0;
      rd_idx_q   <= '0;
    end else begin
      rd_idx_q <= rd_idx_d;
      case (state_q)
        ST_IDLE: begin
          // take a command beat
          if (s_axis_tvalid_i) begin
            cmd_q   <= tft_pkg::cmd_e'(s_axis_tdata_i[tft_pkg::CMD_W-1:0]);
            key_q   <= s_axis_tdata_i[tft_pkg::CMD_W +: KW];
            dur_q   <= s_axis_tdata_i[tft_pkg::CMD_W + KW +: TW];
            el_q    <= s_axis_tdata_i[tft_pkg::CMD_W + KW + TW +: TW];
            idx_q   <= '0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // note the first matching and the first free entry
          if (key_eq && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= idx_q;
          end
          if (!rd_valid && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= idx_q;
          end
          if (idx_q == LAST_IDX) begin
            state_q <= ST_APPLY;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_APPLY: begin
          out_q   <= {{(tft_pkg::OUT_W - tft_pkg::OUT_BITS){1'b0}}, dropped, present};
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // hold the result until it is taken
          if (m_axis_tready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = out_q;

endmodule

// ----- rtl/core/tft_checker.sv -----
module tft_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [tft_pkg::IN_W-1:0]  s_axis_tdata_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [tft_pkg::OUT_W-1:0] m_axis_tdata_o
);

  // One command in flight: no input while a result is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result is pending");

  // An accepted beat closes the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o && !m_axis_tvalid_o)
    else $error("input not closed after a command beat");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Present and dropped never both set, padding is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]) &&
                        (m_axis_tdata_o[tft_pkg::OUT_W-1:tft_pkg::OUT_BITS] == '0))
    else $error("bad result encoding");

endmodule

bind timed_flag_table_core tft_checker u_tft_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
